### sv/mss_pkg.sv
`default_nettype none

package mss_pkg;

   localparam int SAMPLES_PER_AXIS = 10;
   localparam int NUM_AXES         = 3;
   localparam int SAMPLE_W         = 16;
   localparam int LIMIT_W          = 15;
   localparam int INDEX_W          = 4;   // sample index wraps modulo 16
   localparam int COEF_W           = 14;  // largest tap is 9922
   // sum of all taps is 63660 < 2^16, times 2^15 fits a 32-bit signed value
   localparam int ACC_W            = 32;
   localparam int FRAC_W           = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd300;
   localparam logic [7:0]         REQUEST_BASE = 8'h20;

   typedef struct packed {
      logic                       we;
      logic [1:0]                 axis;
      logic [INDEX_W-1:0]         idx;
      logic signed [SAMPLE_W-1:0] value;
   } store_wr_type;

   typedef struct packed {
      logic [1:0] status;
      logic       send_request;
      logic [7:0] request_byte;
      logic       send_read;
   } seq_out_type;

   // Q0.16 smoothing taps, symmetric
   function automatic logic [COEF_W-1:0] tap_coef(input logic [INDEX_W-1:0] idx);
      logic [COEF_W-1:0] c;
      case (idx)
         4'd0, 4'd9: c = 14'd2444;
         4'd1, 4'd8: c = 14'd4188;
         4'd2, 4'd7: c = 14'd6586;
         4'd3, 4'd6: c = 14'd8690;
         4'd4, 4'd5: c = 14'd9922;
         default:    c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/mss_seq.sv
`default_nettype none

module mss_seq #(
   parameter int SamplesPerAxis = mss_pkg::SAMPLES_PER_AXIS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               fire,
   input  wire logic [1:0]                         mode,
   input  wire logic [1:0]                         axis,
   input  wire logic signed [mss_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                               csr_we,
   input  wire logic [mss_pkg::LIMIT_W-1:0]        csr_wdata,
   output mss_pkg::seq_out_type                    seq_out,
   output mss_pkg::store_wr_type                   store_wr
);
   import mss_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SENDING = 2'd1,
      PH_WAITING = 2'd2,
      PH_READING = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MODE_START     = 2'd0,
      MODE_REQ_DONE  = 2'd1,
      MODE_DATA_RDY  = 2'd2,
      MODE_READ_DONE = 2'd3
   } mode_type;

   phase_type          phase_ff, phase_in;
   logic [1:0]         axis_ff, axis_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               send_req, send_rd, outlier;
   logic signed [SAMPLE_W:0] lim_pos, lim_neg, s_ext;
   logic [2:0]         axis_p1;

   assign s_ext   = {sample[SAMPLE_W-1], sample};
   assign lim_pos = {2'b00, limit_ff};
   assign lim_neg = -lim_pos;
   assign outlier = (s_ext > lim_pos) || (s_ext < lim_neg);

   always_comb begin
      phase_in = phase_ff;
      axis_in  = axis_ff;
      index_in = index_ff;
      send_req = 1'b0;
      send_rd  = 1'b0;
      store_wr.we    = 1'b0;
      store_wr.axis  = axis_ff;
      store_wr.idx   = index_ff;
      store_wr.value = sample;
      case (mode_type'(mode))
         MODE_START: begin
            if (phase_ff == PH_IDLE) begin
               axis_in  = axis;
               index_in = '0;
               phase_in = PH_SENDING;
               send_req = 1'b1;
            end
         end
         MODE_REQ_DONE: phase_in = PH_WAITING;
         MODE_DATA_RDY: begin
            phase_in = PH_READING;
            send_rd  = 1'b1;
         end
         MODE_READ_DONE: begin
            if (phase_ff == PH_READING) begin
               store_wr.we = fire && !outlier && (axis_ff < 2'(NUM_AXES))
                             && (32'(index_ff) < SamplesPerAxis);
               index_in = index_ff + INDEX_W'(1);
               if (32'(index_in) >= SamplesPerAxis) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_SENDING;
                  send_req = 1'b1;
               end
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   assign axis_p1 = {1'b0, axis_in} + 3'd1;

   assign seq_out.status       = phase_in;
   assign seq_out.send_request = send_req;
   assign seq_out.request_byte = send_req ? (REQUEST_BASE | {5'b0, axis_p1}) : 8'h00;
   assign seq_out.send_read    = send_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         axis_ff  <= '0;
         index_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (fire) begin
            phase_ff <= phase_in;
            axis_ff  <= axis_in;
            index_ff <= index_in;
         end
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

endmodule

`default_nettype wire

### sv/mss_filt.sv
`default_nettype none

module mss_filt #(
   parameter int SamplesPerAxis = mss_pkg::SAMPLES_PER_AXIS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mss_pkg::store_wr_type  store_wr,
   output logic signed [mss_pkg::SAMPLE_W-1:0] filtered [mss_pkg::NUM_AXES]
);
   import mss_pkg::*;

   localparam int IDX_W = $clog2(SamplesPerAxis);

   // sample store and one running weighted sum per axis; a write adds
   // tap * (new - old) to the sum of its axis
   logic signed [SAMPLE_W-1:0] store_ff [NUM_AXES][SamplesPerAxis];
   logic signed [ACC_W-1:0]    acc_ff [NUM_AXES];
   logic signed [ACC_W-1:0]    acc_in [NUM_AXES];
   logic signed [SAMPLE_W-1:0] old_value;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [COEF_W:0]     coef;
   logic signed [ACC_W-1:0]    prod;
   logic signed [ACC_W-1:0]    biased [NUM_AXES];
   logic [IDX_W-1:0]           wr_idx;

   assign wr_idx    = store_wr.idx[IDX_W-1:0];
   assign old_value = store_wr.we ? store_ff[store_wr.axis][wr_idx] : '0;
   assign diff      = {store_wr.value[SAMPLE_W-1], store_wr.value}
                      - {old_value[SAMPLE_W-1], old_value};
   assign coef      = {1'b0, tap_coef(store_wr.idx)};
   assign prod      = ACC_W'(diff) * ACC_W'(coef);

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         acc_in[a] = acc_ff[a];
         if (store_wr.we && (store_wr.axis == 2'(a))) begin
            acc_in[a] = acc_ff[a] + prod;
         end
         // divide by 2^16 truncating toward zero
         biased[a] = acc_in[a] + (acc_in[a][ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
         filtered[a] = biased[a][FRAC_W +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            acc_ff[a] <= '0;
            for (int i = 0; i < SamplesPerAxis; i++) begin
               store_ff[a][i] <= '0;
            end
         end
      end else begin
         for (int a = 0; a < NUM_AXES; a++) begin
            acc_ff[a] <= acc_in[a];
         end
         if (store_wr.we) begin
            store_ff[store_wr.axis][wr_idx] <= store_wr.value;
         end
      end
   end

endmodule

`default_nettype wire

### sv/magnetometer_sampling_sequencer.sv
`default_nettype none

// Channel   Dir  Ports            Payload (low bit first)
// req       in   req_t*           tuser: mode[1:0]; tdata: axis[1:0], sample[17:2]
// rsp       out  rsp_t*           tdata: status, send_request, request_byte,
//                                 send_read, filtered_x, filtered_y, filtered_z
// csr       in   csr_we/csr_wdata outlier_limit[14:0]
//
// One transfer in, one transfer out. An accepted event is held in the
// input register, is then applied (sequencer state, sample store, per-axis
// running filter sums) and lands in the output register. One event per
// cycle is sustained while rsp_tready is high; the output register stalls
// the input register only while rsp_tready is low and a result is pending.
// Synchronous reset clears the sequencer, the sample store, the filter sums
// and sets the outlier limit to 300; no clearing pass is needed.
module magnetometer_sampling_sequencer #(
   parameter int SamplesPerAxis = mss_pkg::SAMPLES_PER_AXIS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   input  wire logic [23:0] req_tdata,   // axis[1:0], sample[17:2], zero pad
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // status[1:0], send_request[2],
                                         // request_byte[10:3], send_read[11],
                                         // filtered_x[27:12], filtered_y[43:28],
                                         // filtered_z[59:44], zero pad
   // configuration
   input  wire logic        csr_we,
   input  wire logic [14:0] csr_wdata
);
   import mss_pkg::*;

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 mode_ff;
   logic [1:0]                 axis_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [63:0]                out_data_ff;

   logic                       fire;
   seq_out_type                seq_out;
   store_wr_type               store_wr;
   logic signed [SAMPLE_W-1:0] filtered [NUM_AXES];

   // the event in the input register is applied when the output slot frees
   assign fire        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   mss_seq #(
      .SamplesPerAxis(SamplesPerAxis)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .mode      (mode_ff),
      .axis      (axis_ff),
      .sample    (sample_ff),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .seq_out   (seq_out),
      .store_wr  (store_wr)
   );

   // filter sums update only on a store write, which already carries fire
   mss_filt #(
      .SamplesPerAxis(SamplesPerAxis)
   ) u_filt (
      .clock    (clock),
      .reset    (reset),
      .store_wr (store_wr),
      .filtered (filtered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) begin
         mode_ff   <= req_tuser;
         axis_ff   <= req_tdata[1:0];
         sample_ff <= req_tdata[17:2];
      end
      if (fire) begin
         out_data_ff <= {4'b0000, filtered[2], filtered[1], filtered[0],
                         seq_out.send_read, seq_out.request_byte,
                         seq_out.send_request, seq_out.status};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

### verif/mag_seq_checker.sv
`timescale 1ns / 100ps

package mag_event_pkg;

   typedef enum logic [1:0] {
      EV_START,
      EV_REQ_SENT,
      EV_DATA_READY,
      EV_READ_DONE
   } event_mode_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SENDING,
      PH_WAITING,
      PH_READING
   } seq_phase_type;

endpackage

module mag_seq_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [1:0]   req_tuser,
   input  wire logic [23:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [14:0]  csr_wdata,
   output int unsigned       error_count,
   output int unsigned       outstanding
);
   import mss_pkg::*;
   import mag_event_pkg::*;

   // highest field first, so the struct lines up with rsp_tdata[59:0]
   typedef struct packed {
      logic signed [15:0] filtered_z;
      logic signed [15:0] filtered_y;
      logic signed [15:0] filtered_x;
      logic               send_read;
      logic [7:0]         request_byte;
      logic               send_request;
      logic [1:0]         status;
   } mag_result_type;

   seq_phase_type      phase;
   logic [1:0]         cur_axis;
   logic [3:0]         slot_idx;
   logic [14:0]        limit;
   logic signed [15:0] slots [NUM_AXES][SAMPLES_PER_AXIS];
   mag_result_type     expected_results[$];
   int unsigned        accepted_events;
   int unsigned        delivered_results;

   assign outstanding = accepted_events - delivered_results;

   // Q0.16 weights, mirrored around the middle
   function automatic longint tap_weight(input int i);
      int k;
      k = (i < SAMPLES_PER_AXIS - 1 - i) ? i : SAMPLES_PER_AXIS - 1 - i;
      case (k)
         0:       return 2444;
         1:       return 4188;
         2:       return 6586;
         3:       return 8690;
         default: return 9922;
      endcase
   endfunction

   function automatic logic signed [15:0] smoothed_axis(input int a);
      longint acc;
      acc = 0;
      for (int i = 0; i < SAMPLES_PER_AXIS; i++)
         acc += tap_weight(i) * longint'(slots[a][i]);
      acc = acc / 65536;   // truncates toward zero
      return acc[15:0];
   endfunction

   task automatic apply_event(input event_mode_type mode, input logic [1:0] axis,
                              input logic signed [15:0] sample);
      mag_result_type r;
      int             lim;
      r   = '0;
      lim = int'(limit);
      case (mode)
         EV_START: begin
            if (phase == PH_IDLE) begin
               cur_axis       = axis;
               slot_idx       = '0;
               phase          = PH_SENDING;
               r.send_request = 1'b1;
            end
         end
         EV_REQ_SENT: begin
            phase = PH_WAITING;
         end
         EV_DATA_READY: begin
            phase       = PH_READING;
            r.send_read = 1'b1;
         end
         EV_READ_DONE: begin
            if (phase == PH_READING) begin
               if (int'(sample) <= lim && int'(sample) >= -lim &&
                   cur_axis < NUM_AXES && slot_idx < SAMPLES_PER_AXIS)
                  slots[cur_axis][slot_idx] = sample;
               slot_idx = slot_idx + 4'd1;
               if (slot_idx >= SAMPLES_PER_AXIS) begin
                  phase = PH_IDLE;
               end else begin
                  phase          = PH_SENDING;
                  r.send_request = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.status = phase;
      if (r.send_request)
         r.request_byte = REQUEST_BASE | (8'(cur_axis) + 8'd1);
      r.filtered_x = smoothed_axis(0);
      r.filtered_y = smoothed_axis(1);
      r.filtered_z = smoothed_axis(2);
      expected_results.push_back(r);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      mag_result_type want;
      mag_result_type got;
      if (reset) begin
         phase    = PH_IDLE;
         cur_axis = '0;
         slot_idx = '0;
         limit    = LIMIT_RESET;
         for (int a = 0; a < NUM_AXES; a++)
            for (int i = 0; i < SAMPLES_PER_AXIS; i++)
               slots[a][i] = '0;
         expected_results.delete();
         accepted_events   <= 0;
         delivered_results <= 0;
      end else begin
         if (csr_we)
            limit = csr_wdata;
         if (req_tvalid && req_tready) begin
            apply_event(event_mode_type'(req_tuser), req_tdata[1:0], req_tdata[17:2]);
            accepted_events <= accepted_events + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            delivered_results <= delivered_results + 1;
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               got  = mag_result_type'(rsp_tdata[59:0]);
               check_field("status", want.status, got.status);
               check_field("send_request", want.send_request, got.send_request);
               check_field("request_byte", want.request_byte, got.request_byte);
               check_field("send_read", want.send_read, got.send_read);
               check_field("filtered_x", want.filtered_x, got.filtered_x);
               check_field("filtered_y", want.filtered_y, got.filtered_y);
               check_field("filtered_z", want.filtered_z, got.filtered_z);
            end
         end
      end
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import mss_pkg::*;
   import mag_event_pkg::*;

   localparam int ITEM_TARGET   = 1450;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = ITEM_TARGET / NUM_PHASES;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
   localparam int MAX_GAP       = 14;

   // samples pushed through the directed run on the unstored fourth axis
   localparam logic [15:0] EDGE_SAMPLES [SAMPLES_PER_AXIS] = '{
      16'h7FFF, 16'h8000, 16'd300, 16'hFED4, 16'd301,
      16'hFED3, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA
   };

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser    = '0;     // mode[1:0]
   logic [23:0] req_tdata    = '0;     // axis[1:0], sample[17:2], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [63:0] rsp_tdata;             // status[1:0], send_request[2],
                                       // request_byte[10:3], send_read[11],
                                       // filtered_x[27:12], filtered_y[43:28],
                                       // filtered_z[59:44], zero pad
   logic        csr_we       = 1'b0;
   logic [14:0] csr_wdata    = '0;

   int unsigned error_count;
   int unsigned outstanding;

   // shared between the sender and receiver processes
   bit          no_idle         = 1'b0;   // both sides run without gaps
   int unsigned hold_off_cycles = 0;      // one-shot long stall for the receiver
   int unsigned sent_count      = 0;
   logic [14:0] limit_now       = LIMIT_RESET;

   magnetometer_sampling_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   mag_seq_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // single reset at the start, never again
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Run-time guard: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Result receiver. Draws a stall per transfer; a pending long hold-off
   // takes the place of the next stall. tready is only lowered when a stall
   // is actually taken, so it never bounces within one time step.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // One event transfer with a random lead-in gap. tvalid stays high across
   // back-to-back transfers; it is lowered only when a gap is taken.
   task automatic send_event(input event_mode_type mode, input logic [1:0] axis,
                             input logic [15:0] sample);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, sample, axis};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Sample mix: mostly in range, plenty at and just past the outlier limit,
   // plus the 16-bit extremes and fully random words.
   function automatic logic [15:0] pick_sample();
      int lim;
      lim = int'(limit_now);
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'(lim);
         2:       return 16'(-lim);
         3:       return 16'(lim + 1);
         4:       return 16'(-lim - 1);
         5:       return 16'h7FFF;
         6:       return 16'h8000;
         default: return 16'($urandom_range(0, 2 * lim) - lim);
      endcase
   endfunction

   // A full measurement run on a random axis (fourth axis included), with
   // stray events mixed in now and then and an occasional early abandon.
   // Unused fields carry random bits.
   task automatic run_sequence();
      logic [1:0] axis;
      axis = 2'($urandom_range(0, 3));
      send_event(EV_START, axis, 16'($urandom));
      for (int s = 0; s < SAMPLES_PER_AXIS; s++) begin
         if ($urandom_range(0, 11) == 0)
            send_event(event_mode_type'($urandom_range(0, 3)), 2'($urandom),
                       16'($urandom));
         if ($urandom_range(0, 24) == 0)
            break;
         send_event(EV_REQ_SENT, 2'($urandom), 16'($urandom));
         send_event(EV_DATA_READY, 2'($urandom), 16'($urandom));
         send_event(EV_READ_DONE, 2'($urandom), pick_sample());
      end
   endtask

   // Stop offering, let every expected result arrive, then let the
   // pipeline settle so a register write finds the block idle.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_outlier_limit(input logic [14:0] value);
      limit_now = value;
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      while (reset) @(posedge clock);

      // Directed: run on the fourth axis (request byte 0x24, nothing stored)
      // carrying the sample extremes; start while busy is dropped; read done
      // outside reading is dropped; the run ends at the last slot, then a
      // stray data ready from idle lets a read done push the index past it.
      send_event(EV_START, 2'd3, 16'h0000);
      send_event(EV_START, 2'd0, 16'hFFFF);
      send_event(EV_READ_DONE, 2'd1, 16'h1234);
      send_event(EV_REQ_SENT, 2'd2, 16'h0000);
      for (int s = 0; s < SAMPLES_PER_AXIS; s++) begin
         send_event(EV_DATA_READY, 2'd0, 16'h0000);
         send_event(EV_READ_DONE, 2'd0, EDGE_SAMPLES[s]);
      end
      send_event(EV_DATA_READY, 2'd1, 16'hFFFF);
      send_event(EV_READ_DONE, 2'd2, 16'd17);

      // Random phases, one limit setting each (extremes included). Phase 2
      // pairs a long receiver hold-off with a gap-free sender to back the
      // block up; phase 5 is a gap-free stretch on both sides.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_drain();
         case (p)
            0:       write_outlier_limit(15'd0);
            1:       write_outlier_limit(15'h7FFF);
            2:       write_outlier_limit(LIMIT_RESET);
            3:       write_outlier_limit(15'($urandom));
            4:       write_outlier_limit(15'($urandom_range(1, 50)));
            5:       write_outlier_limit(15'd1);
            6:       write_outlier_limit(15'h7FFE);
            default: write_outlier_limit(15'($urandom));
         endcase
         no_idle = (p == 2 || p == 5);
         if (p == 2)
            hold_off_cycles = LONG_HOLD;
         while (sent_count < 26 + (p + 1) * PHASE_ITEMS)
            run_sequence();
      end

      no_idle = 1'b0;
      wait_for_drain();
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
